// ===== rtl/pism_pkg.sv =====
// ----------------------------------------------------------------------------
// pism_pkg
// Shared types, constants and helpers for the pinyin initial subsequence
// matcher: character item format, register indexes and the initial table.
// ----------------------------------------------------------------------------
package pism_pkg;

  localparam int MaxPatternBytes = 32;
  localparam int PatIdxW         = $clog2(MaxPatternBytes);
  localparam int LenW            = $clog2(MaxPatternBytes + 1);
  localparam int CfgDataW        = 64;
  localparam int CfgIdxW         = 3;
  localparam int NumInitials     = 23;

  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] LeadBase   = 8'hA0;
  localparam logic [7:0] LeadLimit  = 8'hA0;

  localparam logic signed [14:0] CodeFirst = 15'sd1601;
  localparam logic signed [14:0] CodeEnd   = 15'sd5590;
  localparam logic [13:0]        RowSize   = 14'd100;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PAT_0_7   = 3'd0,
    REG_PAT_8_15  = 3'd1,
    REG_PAT_16_23 = 3'd2,
    REG_PAT_24_31 = 3'd3,
    REG_PAT_LEN   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_NONE,   // lead byte held, or lone lead at the end
    KIND_ASCII,
    KIND_WIDE,
    KIND_BAD
  } char_kind_t;

  typedef struct packed {
    char_kind_t kind;
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] letter;  // pinyin initial of a wide char, zero if none
    logic       last;
  } char_item_t;

  localparam logic signed [14:0] InitialLow [NumInitials] = '{
    15'sd1601, 15'sd1637, 15'sd1833, 15'sd2078, 15'sd2274, 15'sd2302,
    15'sd2433, 15'sd2594, 15'sd2787, 15'sd3106, 15'sd3212, 15'sd3472,
    15'sd3635, 15'sd3722, 15'sd3730, 15'sd3858, 15'sd4027, 15'sd4086,
    15'sd4390, 15'sd4558, 15'sd4684, 15'sd4925, 15'sd5249
  };

  localparam logic [7:0] InitialLetter [NumInitials] = '{
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
    8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h57,
    8'h58, 8'h59, 8'h5A
  };

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  // ranges are ascending, so the last lower bound passed wins
  function automatic logic [7:0] initial_of(input logic signed [14:0] code);
    logic [7:0] r;
    r = 8'd0;
    if (code >= CodeFirst && code < CodeEnd) begin
      for (int k = 0; k < NumInitials; k++) begin
        if (code >= InitialLow[k]) begin
          r = InitialLetter[k];
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/pism_front.sv =====
// ----------------------------------------------------------------------------
// pism_front
// Byte front end: pairs lead and trail bytes into characters, classifies
// them and looks up the pinyin initial of two-byte characters.
// ----------------------------------------------------------------------------
module pism_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          name_byte,
  input  logic                last_byte,
  output pism_pkg::char_item_t item
);
  import pism_pkg::*;

  logic             held_valid;
  logic [7:0]       held_byte;
  logic [6:0]       lead_off;
  logic [13:0]      row_base;
  logic signed [14:0] code;

  assign lead_off = 7'(held_byte - LeadBase);
  assign row_base = 14'(lead_off) * RowSize;
  assign code     = $signed({1'b0, row_base}) + $signed({7'd0, name_byte})
                    - $signed(15'(LeadBase));

  always_comb begin
    item        = '0;
    item.kind   = KIND_NONE;
    item.lo     = name_byte;
    item.last   = last_byte;
    if (held_valid) begin
      item.kind   = KIND_WIDE;
      item.lead   = held_byte;
      item.letter = initial_of(code);
    end else if (name_byte < AsciiLimit) begin
      item.kind = KIND_ASCII;
    end else if (name_byte < LeadLimit) begin
      item.kind = KIND_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= !held_valid && !last_byte && (name_byte >= LeadLimit);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !held_valid) begin
      held_byte <= name_byte;
    end
  end

endmodule

// ===== rtl/pism_queue.sv =====
// ----------------------------------------------------------------------------
// pism_queue
// Two-entry queue of classified characters between front and back end.
// ----------------------------------------------------------------------------
module pism_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pism_pkg::char_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output pism_pkg::char_item_t head_item
);
  import pism_pkg::*;

  char_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
      (count == 2'd0) |-> !pop)
    else $error("pop from empty queue");

endmodule

// ===== rtl/pism_back.sv =====
// ----------------------------------------------------------------------------
// pism_back
// Match engine: holds the pattern registers, registers each name's result and
// advances the cursor one character per cycle while the result is not stalled.
// ----------------------------------------------------------------------------
module pism_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pism_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pism_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          head_valid,
  input  pism_pkg::char_item_t          head_item,
  output logic                          pop,
  output logic                          matched,
  output logic                          out_valid,
  input  logic                          out_ready
);
  import pism_pkg::*;

  logic [CfgDataW-1:0] pat_words [4];
  logic [LenW-1:0]     pat_len_raw;
  logic [LenW-1:0]     pat_len;

  logic [LenW-1:0] cur;
  logic [LenW-1:0] cur_next;
  logic            done;
  logic            done_next;
  logic            rej;
  logic            rej_next;
  logic            result;

  logic [PatIdxW-1:0] idx0;
  logic [PatIdxW-1:0] idx1;
  logic [7:0]         pat0;
  logic [7:0]         pat1;
  logic [7:0]         src;
  logic [LenW-1:0]    adv;
  logic               step_ok;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_words[0] <= '0;
      pat_words[1] <= '0;
      pat_words[2] <= '0;
      pat_words[3] <= '0;
      pat_len_raw  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAT_0_7:   pat_words[0] <= cfg_data;
        REG_PAT_8_15:  pat_words[1] <= cfg_data;
        REG_PAT_16_23: pat_words[2] <= cfg_data;
        REG_PAT_24_31: pat_words[3] <= cfg_data;
        REG_PAT_LEN:   pat_len_raw  <= cfg_data[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign pat_len = (pat_len_raw > LenW'(MaxPatternBytes)) ?
                   LenW'(MaxPatternBytes) : pat_len_raw;

  assign idx0 = cur[PatIdxW-1:0];
  assign idx1 = idx0 + PatIdxW'(1);
  assign pat0 = pat_words[idx0[PatIdxW-1:3]][{idx0[2:0], 3'b000} +: 8];
  assign pat1 = pat_words[idx1[PatIdxW-1:3]][{idx1[2:0], 3'b000} +: 8];

  assign src = (head_item.kind == KIND_ASCII) ? to_upper(head_item.lo)
                                              : head_item.letter;

  always_comb begin
    cur_next  = cur;
    done_next = done;
    rej_next  = rej;
    adv       = cur;
    step_ok   = 1'b0;
    if (!done && !rej) begin
      case (head_item.kind) inside
        KIND_BAD: rej_next = 1'b1;
        KIND_ASCII, KIND_WIDE: begin
          if (pat_len != '0 && cur < pat_len) begin
            if (pat0 < AsciiLimit) begin
              if (src != 8'd0 && src == to_upper(pat0)) begin
                adv     = cur + LenW'(1);
                step_ok = 1'b1;
              end
            end else if (pat0 < LeadLimit || (cur + LenW'(1)) >= pat_len) begin
              rej_next = 1'b1;
            end else if (head_item.kind == KIND_WIDE && head_item.lead == pat0 &&
                         head_item.lo == pat1) begin
              adv     = cur + LenW'(2);
              step_ok = 1'b1;
            end
            if (step_ok) begin
              cur_next = adv;
              if (adv >= pat_len) begin
                done_next = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
    result = done_next && !rej_next;
  end

  // the last character of a name waits until the result register is free
  assign pop = head_valid && (!head_item.last || !out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur  <= '0;
      done <= 1'b0;
      rej  <= 1'b0;
    end else if (pop) begin
      if (head_item.last) begin
        cur  <= '0;
        done <= 1'b0;
        rej  <= 1'b0;
      end else begin
        cur  <= cur_next;
        done <= done_next;
        rej  <= rej_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head_item.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.last) begin
      matched <= result;
    end
  end

  a_done_rej_excl: assert property (@(posedge clk) disable iff (rst) !(done && rej))
    else $error("match and reject both set");
  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
      cur <= LenW'(MaxPatternBytes + 1))
    else $error("pattern cursor out of range");
  a_name_clear: assert property (@(posedge clk) disable iff (rst)
      pop && head_item.last |=> cur == '0 && !done && !rej)
    else $error("name state not cleared after last byte");

endmodule

// ===== rtl/pinyin_initial_subsequence_match.sv =====
// ----------------------------------------------------------------------------
// pinyin_initial_subsequence_match
// Streams GB2312 name bytes and reports whether the configured pattern
// occurs as a subsequence, matching letters by ASCII or pinyin initial and wide characters exactly.
// ----------------------------------------------------------------------------
// result path: the last byte of a name is written into the queue, then popped
// into the match engine, which registers matched and out_valid
// throughput: one name byte per cycle while the queue is not full, set by the
// cursor update in the match engine; the two-entry queue buffers bytes during output stall
// reset: synchronous, clears pattern registers, cursor, queue and out_valid, not matched
module pinyin_initial_subsequence_match (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pism_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pism_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    name_byte,
  input  logic                          last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          matched
);
  import pism_pkg::*;

  char_item_t front_item;
  char_item_t head_item;
  logic       accept;
  logic       q_full;
  logic       head_valid;
  logic       pop;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  pism_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .name_byte (name_byte),
    .last_byte (last_byte),
    .item      (front_item)
  );

  pism_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  pism_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .matched    (matched),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule

// ===== test/tb_pinyin_initial_subsequence_match.sv =====
// ----------------------------------------------------------------------------
// tb_pinyin_initial_subsequence_match
// Streams GB2312 name bytes through the matcher under a series of search
// patterns and checks every per-name match flag against a cycle-free
// predictor of the cursor, held lead byte and reject logic, or a flag given by the plan.
// ----------------------------------------------------------------------------
module tb_pinyin_initial_subsequence_match;
  timeunit 1ns;
  timeprecision 1ps;

  import pism_pkg::*;

  localparam int StallLimit   = 2000;
  localparam int RandomItems  = 600;
  localparam int PatternSlots = 32;

  localparam logic [7:0] AsciiTop  = 8'h80;
  localparam logic [7:0] LeadFirst = 8'hA0;

  typedef struct packed {
    logic         load;
    logic [255:0] text;
    logic [5:0]   len;
    logic [7:0]   data_byte;
    logic         last;
    logic         typed;
    logic         want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  cfg_reg_t            cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          name_byte;
  logic                last_byte;
  logic                out_valid;
  logic                out_ready;
  logic                matched;

  // predictor copy of the block
  logic [63:0] pat_word [4];
  logic [5:0]  pat_len;
  logic [5:0]  cursor;
  logic [7:0]  held;
  logic        held_v;
  logic        done;
  logic        rejected;

  logic        match_due [$];
  logic        due_match;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          sent_items;
  int          taken_results;
  logic        tag_typed;
  logic        tag_want;
  logic        in_quiet;
  logic        out_quiet;

  logic [7:0]  phase_pat [PatternSlots];
  int          phase_used;
  logic [7:0]  name_q [$];

  pinyin_initial_subsequence_match dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .name_byte (name_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .matched   (matched)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] letter_for_code(input int code);
    if (code < 1601 || code >= 5590) return 8'd0;
    if (code >= 5249) return "Z";
    if (code >= 4925) return "Y";
    if (code >= 4684) return "X";
    if (code >= 4558) return "W";
    if (code >= 4390) return "T";
    if (code >= 4086) return "S";
    if (code >= 4027) return "R";
    if (code >= 3858) return "Q";
    if (code >= 3730) return "P";
    if (code >= 3722) return "O";
    if (code >= 3635) return "N";
    if (code >= 3472) return "M";
    if (code >= 3212) return "L";
    if (code >= 3106) return "K";
    if (code >= 2787) return "J";
    if (code >= 2594) return "H";
    if (code >= 2433) return "G";
    if (code >= 2302) return "F";
    if (code >= 2274) return "E";
    if (code >= 2078) return "D";
    if (code >= 1833) return "C";
    if (code >= 1637) return "B";
    return "A";
  endfunction

  function automatic int pair_code(input logic [7:0] lead, input logic [7:0] lo);
    return (int'(lead) - 160) * 100 + int'(lo) - 160;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [7:0] pattern_at(input int idx);
    int k;
    k = idx & 31;
    return pat_word[k >> 3][(k & 7) * 8 +: 8];
  endfunction

  function automatic void clear_name();
    cursor   = '0;
    held     = '0;
    held_v   = 1'b0;
    done     = 1'b0;
    rejected = 1'b0;
  endfunction

  function automatic void advance_cursor(input logic wide, input logic [7:0] lead,
                                         input logic [7:0] lo);
    int         len;
    int         cur;
    logic [7:0] p;
    logic [7:0] src;
    len = (pat_len > 6'd32) ? 32 : int'(pat_len);
    cur = int'(cursor);
    if (len == 0 || cur >= len) return;
    p = pattern_at(cur);
    if (p < AsciiTop) begin
      src = wide ? letter_for_code(pair_code(lead, lo)) : fold_case(lo);
      if (src != 8'd0 && src == fold_case(p)) cur++;
    end else if (p < LeadFirst || cur + 1 >= len) begin
      // bad or cut-off pattern character
      rejected = 1'b1;
      return;
    end else if (wide && lead == p && lo == pattern_at(cur + 1)) begin
      cur += 2;
    end
    cursor = 6'(cur);
    if (cur >= len) done = 1'b1;
  endfunction

  function automatic void track_name_byte(input logic [7:0] b, input logic last,
                                          input logic typed, input logic want);
    if (!done && !rejected) begin
      if (held_v) begin
        held_v = 1'b0;
        advance_cursor(1'b1, held, b);
      end else if (b < AsciiTop) begin
        advance_cursor(1'b0, 8'd0, b);
      end else if (b < LeadFirst) begin
        rejected = 1'b1;
      end else begin
        held   = b;
        held_v = 1'b1;
      end
    end
    if (last) begin
      match_due = {match_due, (typed ? want : (done && !rejected))};
      clear_name();
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        track_name_byte(name_byte, last_byte, tag_typed, tag_want);
      end
      if (out_valid && out_ready) begin
        if (match_due.size() == 0) begin
          $error("matched: expected none, actual %0d", matched);
          mismatches++;
        end else begin
          due_match = match_due.pop_front();
          if (matched !== due_match) begin
            $error("matched: expected %0d, actual %0d", due_match, matched);
            mismatches++;
          end
        end
      end
      quiet_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ?
                      0 : quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < StallLimit) @(negedge clk);
    $display("pinyin_initial_subsequence_match: mismatch");
    $finish;
  end

  // result side: random stall ahead of each result transfer, none in quiet phases
  initial begin
    int stall;
    out_ready     = 1'b0;
    out_quiet     = 1'b0;
    taken_results = 0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (taken_results % 20 == 0) out_quiet = ($urandom_range(0, 3) == 0);
      stall = out_quiet ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken_results++;
      @(negedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input logic want);
    int gap;
    if (sent_items % 40 == 0) in_quiet = ($urandom_range(0, 3) == 0);
    gap = in_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    name_byte <= b;
    last_byte <= last;
    tag_typed <= typed;
    tag_want  <= want;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    @(negedge clk);
  endtask

  // drain all results, then allow for a trailing byte still in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (match_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t sel, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    case (sel)
      REG_PAT_0_7:   pat_word[0] = data;
      REG_PAT_8_15:  pat_word[1] = data;
      REG_PAT_16_23: pat_word[2] = data;
      REG_PAT_24_31: pat_word[3] = data;
      REG_PAT_LEN:   pat_len = data[5:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_pattern(input logic [255:0] text, input logic [5:0] len);
    put_reg(REG_PAT_0_7, text[63:0]);
    put_reg(REG_PAT_8_15, text[127:64]);
    put_reg(REG_PAT_16_23, text[191:128]);
    put_reg(REG_PAT_24_31, text[255:192]);
    put_reg(REG_PAT_LEN, {58'd0, len});
    cfg_we <= 1'b0;
  endtask

  function automatic plan_row_t byte_row(input logic [7:0] b, input logic last);
    plan_row_t r;
    r           = '0;
    r.data_byte = b;
    r.last      = last;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [7:0] b, input logic want);
    plan_row_t r;
    r           = '0;
    r.data_byte = b;
    r.last      = 1'b1;
    r.typed     = 1'b1;
    r.want      = want;
    return r;
  endfunction

  function automatic plan_row_t load_row(input logic [255:0] text, input logic [5:0] len);
    plan_row_t r;
    r      = '0;
    r.load = 1'b1;
    r.text = text;
    r.len  = len;
    return r;
  endfunction

  // pick 0: saturated length, 1: all-ones pattern, 2: empty, else random
  function automatic logic [5:0] make_pattern(input int pick);
    int         i;
    int         r;
    logic [5:0] len;
    for (i = 0; i < PatternSlots; i++) phase_pat[i] = 8'($urandom);
    r = $urandom_range(0, 9);
    if (pick == 0) len = 6'd63;
    else if (pick == 1) len = 6'd32;
    else if (pick == 2 || r == 0) len = 6'd0;
    else if (r == 1) len = 6'd32;
    else if (r == 2) len = 6'($urandom_range(33, 63));
    else len = 6'($urandom_range(1, 8));
    phase_used = (len > 6'd32) ? 32 : int'(len);
    if (pick == 1) begin
      for (i = 0; i < PatternSlots; i++) phase_pat[i] = 8'hFF;
      return len;
    end
    i = 0;
    while (i < phase_used) begin
      r = $urandom_range(0, 99);
      if (i + 1 == phase_used && r >= 70 && r < 97 && $urandom_range(0, 3) != 0) r = 0;
      if (r < 60) begin
        phase_pat[i] = 8'("A" + $urandom_range(0, 25));
        if ($urandom_range(0, 1) == 1) phase_pat[i] = phase_pat[i] ^ 8'h20;
        i++;
      end else if (r < 70) begin
        phase_pat[i] = 8'($urandom_range(0, 127));
        i++;
      end else if (r < 97) begin
        // a lead on the last slot leaves the character cut off
        phase_pat[i] = 8'($urandom_range(8'hA0, 8'hFF));
        if (i + 1 < phase_used) phase_pat[i + 1] = 8'($urandom);
        i += 2;
      end else begin
        phase_pat[i] = 8'($urandom_range(8'h80, 8'h9F));
        i++;
      end
    end
    return len;
  endfunction

  function automatic void push_noise();
    if ($urandom_range(0, 1) == 0) begin
      name_q = {name_q, 8'($urandom_range(0, 127))};
    end else begin
      name_q = {name_q, 8'($urandom_range(8'hA0, 8'hFF))};
      name_q = {name_q, 8'($urandom)};
    end
  endfunction

  function automatic void push_wide_letter(input logic [7:0] letter);
    logic [7:0] lead;
    logic [7:0] lo;
    do begin
      lead = 8'($urandom_range(8'hA0, 8'hFF));
      lo   = 8'($urandom);
    end while (letter_for_code(pair_code(lead, lo)) != letter);
    name_q = {name_q, lead};
    name_q = {name_q, lo};
  endfunction

  // mostly a name that carries the pattern with noise between, sometimes broken
  function automatic void build_name();
    int         i;
    int         step;
    logic [7:0] p;
    logic [7:0] u;
    name_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) name_q = {name_q, 8'($urandom)};
      return;
    end
    i = 0;
    while (i < phase_used) begin
      if ($urandom_range(0, 3) == 0) push_noise();
      if ($urandom_range(0, 49) == 0) name_q = {name_q, 8'($urandom_range(8'h80, 8'h9F))};
      p    = phase_pat[i];
      step = (p >= LeadFirst && i + 1 < phase_used) ? 2 : 1;
      if ($urandom_range(0, 19) != 0) begin
        u = fold_case(p);
        if (p >= LeadFirst && step == 2) begin
          name_q = {name_q, p};
          name_q = {name_q, phase_pat[i + 1]};
        end else if (p >= AsciiTop) begin
          name_q = {name_q, 8'("a" + $urandom_range(0, 25))};
        end else if (u >= "A" && u <= "Z" && u != "I" && u != "U" && u != "V" &&
                     $urandom_range(0, 1) == 1) begin
          push_wide_letter(u);
        end else if (u >= "A" && u <= "Z" && $urandom_range(0, 1) == 1) begin
          name_q = {name_q, p ^ 8'h20};
        end else begin
          name_q = {name_q, p};
        end
      end
      i += step;
    end
    repeat ($urandom_range(0, 2)) push_noise();
    if ($urandom_range(0, 19) == 0) name_q = {name_q, 8'($urandom_range(8'hA0, 8'hFF))};
    if (name_q.size() == 0) push_noise();
  endfunction

  initial begin
    plan_row_t    plan [$];
    logic [255:0] text;
    logic [5:0]   plen;
    int           budget;
    int           pick;
    int           phase_items;

    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = REG_PAT_0_7;
    cfg_data   = '0;
    in_valid   = 1'b0;
    name_byte  = 8'd0;
    last_byte  = 1'b0;
    tag_typed  = 1'b0;
    tag_want   = 1'b0;
    in_quiet   = 1'b0;
    sent_items = 0;
    for (int w = 0; w < 4; w++) pat_word[w] = '0;
    pat_len = '0;
    clear_name();

    // empty pattern out of reset
    plan = {plan, known_row(8'h61, 1'b0)};
    plan = {plan, load_row(256'hA1B04261, 6'd4)};
    // plain letter, pinyin initial, identical wide character
    plan = {plan, byte_row(8'h41, 1'b0)};
    plan = {plan, byte_row(8'hB1, 1'b0)};
    plan = {plan, byte_row(8'hA1, 1'b0)};
    plan = {plan, byte_row(8'hB0, 1'b0)};
    plan = {plan, byte_row(8'hA1, 1'b1)};
    // bad lead byte rejects the name
    plan = {plan, byte_row(8'h85, 1'b0)};
    plan = {plan, byte_row(8'h61, 1'b0)};
    plan = {plan, known_row(8'h42, 1'b0)};
    // bytes after a full match are ignored
    plan = {plan, byte_row(8'h61, 1'b0)};
    plan = {plan, byte_row(8'h62, 1'b0)};
    plan = {plan, byte_row(8'hB0, 1'b0)};
    plan = {plan, byte_row(8'hA1, 1'b0)};
    plan = {plan, byte_row(8'h9F, 1'b0)};
    plan = {plan, byte_row(8'hFF, 1'b1)};
    // lone lead at the end
    plan = {plan, byte_row(8'h61, 1'b0)};
    plan = {plan, byte_row(8'h62, 1'b0)};
    plan = {plan, known_row(8'hB0, 1'b0)};
    // code with no initial, byte extremes, top of the table
    plan = {plan, load_row(256'h7A, 6'd1)};
    plan = {plan, byte_row(8'hFF, 1'b0)};
    plan = {plan, byte_row(8'hFF, 1'b0)};
    plan = {plan, byte_row(8'h00, 1'b0)};
    plan = {plan, byte_row(8'h7F, 1'b0)};
    plan = {plan, byte_row(8'hD7, 1'b0)};
    plan = {plan, byte_row(8'hF9, 1'b1)};
    // bad pattern character
    plan = {plan, load_row(256'h8561, 6'd2)};
    plan = {plan, byte_row(8'h61, 1'b0)};
    plan = {plan, known_row(8'h62, 1'b0)};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[k]) begin
      if (plan[k].load) begin
        settle();
        load_pattern(plan[k].text, plan[k].len);
      end else begin
        send_byte(plan[k].data_byte, plan[k].last, plan[k].typed, plan[k].want);
      end
    end

    budget = 0;
    pick   = 0;
    while (budget < RandomItems) begin
      settle();
      plen = make_pattern(pick);
      pick++;
      for (int s = 0; s < PatternSlots; s++) text[8 * s +: 8] = phase_pat[s];
      load_pattern(text, plen);
      phase_items = 0;
      while (phase_items < 40) begin
        build_name();
        foreach (name_q[n]) begin
          send_byte(name_q[n], n == name_q.size() - 1, 1'b0, 1'b0);
        end
        phase_items += name_q.size();
      end
      budget += phase_items;
    end

    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("pinyin_initial_subsequence_match: match");
    end else begin
      $display("pinyin_initial_subsequence_match: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pism_pkg.sv
rtl/pism_front.sv
rtl/pism_queue.sv
rtl/pism_back.sv
rtl/pinyin_initial_subsequence_match.sv
test/tb_pinyin_initial_subsequence_match.sv
